[rtl/mdhf_pkg.sv]
package mdhf_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_ROWS = 3;
  localparam logic [1:0] LAST_ROW = 2'd2;

  typedef struct packed {
    logic signed [31:0] link_length;
    logic [15:0]        link_twist;
    logic signed [31:0] link_offset;
    logic [15:0]        joint_angle;
    logic               last_joint;
    logic               first_joint;
  } joint_t;

  typedef struct packed {
    logic   valid;
    joint_t joint;
  } queue_rd_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/mdhf_if.sv]
interface mdhf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] link_length;
  logic [15:0]        link_twist;
  logic signed [31:0] link_offset;
  logic [15:0]        joint_angle;
  logic               last_joint;

  modport source (output valid, link_length, link_twist, link_offset, joint_angle,
                  last_joint, input ready);
  modport sink (input valid, link_length, link_twist, link_offset, joint_angle,
                last_joint, output ready);
endinterface

interface mdhf_out_if #(
  parameter int ROT_W = 18
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              row_index;
  logic signed [ROT_W-1:0] rot_col0;
  logic signed [ROT_W-1:0] rot_col1;
  logic signed [ROT_W-1:0] rot_col2;
  logic signed [31:0]      translation;
  logic                    last_row;

  modport source (output valid, row_index, rot_col0, rot_col1, rot_col2, translation,
                  last_row, input ready);
  modport sink (input valid, row_index, rot_col0, rot_col1, rot_col2, translation,
                last_row, output ready);
endinterface

[rtl/mdhf_queue.sv]
module mdhf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mdhf_pkg::joint_t  push_joint,
  output logic              full,
  input  logic              pop,
  output mdhf_pkg::queue_rd_t rd
);

  localparam int DEPTH = mdhf_pkg::QUEUE_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mdhf_pkg::joint_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full = (count_r == CW'(DEPTH));
  assign rd.valid = (count_r != '0);
  assign rd.joint = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_joint;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/mdhf_front.sv]
module mdhf_front (
  input  logic             clk,
  input  logic             rst_n,
  mdhf_in_if.sink          in_chan,
  input  logic             q_full,
  output logic             q_push,
  output mdhf_pkg::joint_t q_joint
);

  logic started_r;

  assign in_chan.ready = !q_full;
  assign q_push = in_chan.valid && !q_full;

  always_comb begin
    q_joint.link_length = in_chan.link_length;
    q_joint.link_twist  = in_chan.link_twist;
    q_joint.link_offset = in_chan.link_offset;
    q_joint.joint_angle = in_chan.joint_angle;
    q_joint.last_joint  = in_chan.last_joint;
    // first joint of a chain loads the accumulator instead of multiplying
    q_joint.first_joint = !started_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else if (q_push) begin
      started_r <= !in_chan.last_joint;
    end
  end

endmodule

[rtl/mdhf_back.sv]
module mdhf_back #(
  parameter int ANGLE_BITS = 16,
  parameter int ROT_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mdhf_pkg::queue_rd_t q_rd,
  output logic                q_pop,
  mdhf_out_if.source          out_chan
);

  localparam int RF = ROT_FRAC_BITS;
  localparam int RW = ROT_FRAC_BITS + 2;
  localparam int PW = RW + 32;
  localparam int SW = RW + 34;
  localparam int CSH = 30 - ROT_FRAC_BITS;
  localparam int ASH = 32 - ANGLE_BITS;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic signed [33:0] C_HALF = (CSH == 0) ? 34'sd0 : 34'sd1 <<< (CSH - 1);
  localparam logic signed [33:0] C_ONE = 34'sd1 <<< RF;
  localparam logic signed [SW-1:0] P_HALF = SW'(1) <<< (RF - 1);
  localparam logic signed [SW-1:0] P_ONE = SW'(1) <<< RF;
  localparam logic signed [SW-1:0] TR_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] TR_MIN = -SW'(64'sd2147483648);
  localparam logic [4:0] LAST_STEP = 5'(mdhf_pkg::CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CORD, S_LMUL, S_LACC, S_MMUL, S_MACC, S_EMIT
  } state_t;

  state_t state_r;
  logic [4:0] cnt_r;
  logic theta_r, neg_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic signed [RW-1:0] sa_r, ca_r, st_r;
  mdhf_pkg::joint_t job_r;
  logic [2:0] op_r;
  logic [1:0] r_r, c_r, k_r, emit_idx_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] sum_r;
  logic signed [RW-1:0] lr_r [9];
  logic signed [31:0] lt_r [3];
  logic signed [RW-1:0] acc_rot_r [9];
  logic signed [31:0] acc_tr_r [3];
  logic signed [RW-1:0] tmp_r [3];
  logic out_valid_r;

  function automatic logic [34:0] ang_prep(input logic [15:0] ang);
    logic [31:0] a;
    logic neg;
    a = (32'(ang) & AMASK) << ASH;
    neg = a[31] ^ a[30];
    if (neg) begin
      a[31] = ~a[31];
    end
    return {neg, 34'(signed'(a))};
  endfunction

  function automatic logic signed [RW-1:0] cord_fin(input logic signed [33:0] v,
                                                    input logic neg);
    logic signed [33:0] r;
    r = (v + C_HALF) >>> CSH;
    if (neg) begin
      r = -r;
    end
    if (r > C_ONE) begin
      r = C_ONE;
    end else if (r < -C_ONE) begin
      r = -C_ONE;
    end
    return RW'(r);
  endfunction

  function automatic logic signed [RW-1:0] rot_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (r > P_ONE) begin
      r = P_ONE;
    end else if (r < -P_ONE) begin
      r = -P_ONE;
    end
    return RW'(r);
  endfunction

  function automatic logic signed [31:0] tr_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (r > TR_MAX) begin
      r = TR_MAX;
    end else if (r < TR_MIN) begin
      r = TR_MIN;
    end
    return 32'(r);
  endfunction

  // cordic step
  logic signed [33:0] shx, shy, at, xn, yn, zn;
  logic [34:0] prep_tw, prep_th;
  logic signed [RW-1:0] cos_v, sin_v;

  always_comb begin
    shx = x_r >>> cnt_r;
    shy = y_r >>> cnt_r;
    at = 34'(mdhf_pkg::atan_turn(cnt_r));
    if (!z_r[33]) begin
      xn = x_r - shy;
      yn = y_r + shx;
      zn = z_r - at;
    end else begin
      xn = x_r + shy;
      yn = y_r - shx;
      zn = z_r + at;
    end
    cos_v = cord_fin(xn, neg_r);
    sin_v = cord_fin(yn, neg_r);
    prep_tw = ang_prep(q_rd.joint.link_twist);
    prep_th = ang_prep(job_r.joint_angle);
  end

  // shared multiplier operands
  logic signed [RW-1:0] mul_a;
  logic signed [31:0] mul_b;
  logic [3:0] idx_a, idx_b;
  logic signed [RW-1:0] neg_sa;

  always_comb begin
    neg_sa = -sa_r;
    idx_a = 4'(r_r) * 4'd3 + 4'(k_r);
    idx_b = 4'(k_r) * 4'd3 + 4'(c_r);
    if (state_r == S_LMUL) begin
      case (op_r)
        3'd0: begin mul_a = lr_r[0]; mul_b = 32'(ca_r); end
        3'd1: begin mul_a = lr_r[0]; mul_b = 32'(ca_r); end
        3'd2: begin mul_a = lr_r[0]; mul_b = 32'(sa_r); end
        3'd3: begin mul_a = lr_r[0]; mul_b = 32'(sa_r); end
        3'd4: begin mul_a = neg_sa; mul_b = job_r.link_offset; end
        default: begin mul_a = ca_r; mul_b = job_r.link_offset; end
      endcase
      // st for even ops, ct for odd ops among the first four
      if (op_r == 3'd0 || op_r == 3'd2) begin
        mul_a = st_r;
      end
    end else begin
      mul_a = acc_rot_r[idx_a];
      mul_b = (c_r == 2'd3) ? lt_r[k_r] : 32'(lr_r[idx_b]);
    end
  end

  // product rounding
  logic signed [SW-1:0] acc_base, sum_v, rnd;
  logic signed [RW-1:0] rs;
  logic signed [31:0] ts, tacc;

  always_comb begin
    acc_base = (state_r == S_LACC || k_r == 2'd0) ? '0 : sum_r;
    sum_v = acc_base + SW'(prod_r);
    rnd = (sum_v + P_HALF) >>> RF;
    rs = rot_sat(rnd);
    ts = tr_sat(rnd);
    tacc = tr_sat(rnd + SW'(acc_tr_r[r_r]));
  end

  assign q_pop = (state_r == S_IDLE) && q_rd.valid;

  assign out_chan.valid = out_valid_r;
  assign out_chan.row_index = emit_idx_r;
  assign out_chan.rot_col0 = acc_rot_r[0];
  assign out_chan.rot_col1 = acc_rot_r[1];
  assign out_chan.rot_col2 = acc_rot_r[2];
  assign out_chan.translation = acc_tr_r[0];
  assign out_chan.last_row = (emit_idx_r == mdhf_pkg::LAST_ROW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      emit_idx_r <= '0;
      cnt_r <= '0;
      theta_r <= 1'b0;
      op_r <= '0;
      r_r <= '0;
      c_r <= '0;
      k_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_rd.valid) begin
            job_r <= q_rd.joint;
            x_r <= 34'(mdhf_pkg::CORDIC_GAIN_Q30);
            y_r <= '0;
            z_r <= prep_tw[33:0];
            neg_r <= prep_tw[34];
            cnt_r <= '0;
            theta_r <= 1'b0;
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          x_r <= xn;
          y_r <= yn;
          z_r <= zn;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            cnt_r <= '0;
            if (!theta_r) begin
              sa_r <= sin_v;
              ca_r <= cos_v;
              theta_r <= 1'b1;
              x_r <= 34'(mdhf_pkg::CORDIC_GAIN_Q30);
              y_r <= '0;
              z_r <= prep_th[33:0];
              neg_r <= prep_th[34];
            end else begin
              st_r <= sin_v;
              lr_r[0] <= cos_v;
              lr_r[1] <= -sin_v;
              lr_r[2] <= '0;
              lr_r[5] <= -sa_r;
              lr_r[8] <= ca_r;
              lt_r[0] <= job_r.link_length;
              op_r <= '0;
              state_r <= S_LMUL;
            end
          end
        end
        S_LMUL: begin
          prod_r <= mul_a * mul_b;
          state_r <= S_LACC;
        end
        S_LACC: begin
          op_r <= op_r + 1'b1;
          state_r <= S_LMUL;
          case (op_r)
            3'd0: lr_r[3] <= rs;
            3'd1: lr_r[4] <= rs;
            3'd2: lr_r[6] <= rs;
            3'd3: lr_r[7] <= rs;
            3'd4: lt_r[1] <= ts;
            default: begin
              lt_r[2] <= ts;
              r_r <= '0;
              c_r <= '0;
              k_r <= '0;
              if (job_r.first_joint) begin
                acc_rot_r <= lr_r;
                acc_tr_r[0] <= lt_r[0];
                acc_tr_r[1] <= lt_r[1];
                acc_tr_r[2] <= ts;
                out_valid_r <= job_r.last_joint;
                emit_idx_r <= '0;
                state_r <= job_r.last_joint ? S_EMIT : S_IDLE;
              end else begin
                state_r <= S_MMUL;
              end
            end
          endcase
        end
        S_MMUL: begin
          prod_r <= mul_a * mul_b;
          state_r <= S_MACC;
        end
        S_MACC: begin
          sum_r <= sum_v;
          state_r <= S_MMUL;
          if (k_r != 2'd2) begin
            k_r <= k_r + 1'b1;
          end else begin
            k_r <= '0;
            if (c_r != 2'd3) begin
              tmp_r[c_r] <= rs;
              c_r <= c_r + 1'b1;
            end else begin
              // row finished: translation used the old row, now commit it
              c_r <= '0;
              acc_rot_r[idx_a - 4'd2] <= tmp_r[0];
              acc_rot_r[idx_a - 4'd1] <= tmp_r[1];
              acc_rot_r[idx_a] <= tmp_r[2];
              acc_tr_r[r_r] <= tacc;
              if (r_r == mdhf_pkg::LAST_ROW) begin
                r_r <= '0;
                out_valid_r <= job_r.last_joint;
                emit_idx_r <= '0;
                state_r <= job_r.last_joint ? S_EMIT : S_IDLE;
              end else begin
                r_r <= r_r + 1'b1;
              end
            end
          end
        end
        S_EMIT: begin
          if (out_chan.ready) begin
            // rows move up so the output always shows row zero
            for (int i = 0; i < 6; i++) begin
              acc_rot_r[i] <= acc_rot_r[i + 3];
            end
            acc_tr_r[0] <= acc_tr_r[1];
            acc_tr_r[1] <= acc_tr_r[2];
            emit_idx_r <= emit_idx_r + 1'b1;
            if (emit_idx_r == mdhf_pkg::LAST_ROW) begin
              out_valid_r <= 1'b0;
              emit_idx_r <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_EMIT)
    else $error("result shown outside emit");

  a_cordic_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CORD |-> cnt_r <= LAST_STEP)
    else $error("cordic step count out of range");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_chan.ready && emit_idx_r == mdhf_pkg::LAST_ROW
    |=> state_r == S_IDLE && !out_valid_r)
    else $error("emit did not finish after last row");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_CORD && cnt_r == 5'd0 && !theta_r)
    else $error("joint taken without starting cordic");

endmodule

[rtl/mdh_forward_kinematics_chain_unit.sv]
// channel    dir  fields                                              request
// in_chan    in   link_length, link_twist, link_offset, joint_angle,  one joint
//                 last_joint
// out_chan   out  row_index, rot_col0..2, translation, last_row       one row
//
// a joint runs the cordic for its twist, then for its angle, then builds its link matrix
// on the shared multiplier and folds it into the chain, which a first joint loads instead
// the single multiplier and the one-step-per-cycle cordic set the pace of this work
// a last joint then shows three rows, one per cycle while out_chan is ready
// rst_n is synchronous; the two-entry queue keeps taking joints while rows stall
module mdh_forward_kinematics_chain_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int ROT_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mdhf_in_if.sink    in_chan,
  mdhf_out_if.source out_chan
);

  logic q_push, q_full, q_pop;
  mdhf_pkg::joint_t q_joint;
  mdhf_pkg::queue_rd_t q_rd;

  mdhf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_joint (q_joint)
  );

  mdhf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_joint (q_joint),
    .full       (q_full),
    .pop        (q_pop),
    .rd         (q_rd)
  );

  mdhf_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rd     (q_rd),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

[tb/sv/tb_mdhf_if.sv]
`timescale 1ns / 100ps

// interfaces come from the rtl; this file only carries the joint request and pose row types used by the bench
package tb_mdhf_types_pkg;
  typedef struct {
    logic signed [31:0] link_length;
    logic [15:0]        link_twist;
    logic signed [31:0] link_offset;
    logic [15:0]        joint_angle;
    logic               last_joint;
  } joint_req_t;

  typedef struct {
    logic [1:0]         row_index;
    logic signed [17:0] rot_col0;
    logic signed [17:0] rot_col1;
    logic signed [17:0] rot_col2;
    logic signed [31:0] translation;
    logic               last_row;
  } pose_row_t;
endpackage

[tb/sv/tb_mdh_forward_kinematics_chain_unit.sv]
`timescale 1ns / 100ps

module tb_mdh_forward_kinematics_chain_unit;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 <<< FRAC;

  logic clk;
  logic rst_n;

  mdhf_in_if in_chan ();
  mdhf_out_if #(.ROT_W(18)) out_chan ();

  mdh_forward_kinematics_chain_unit #(
    .ANGLE_BITS(16),
    .ROT_FRAC_BITS(FRAC)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan.sink),
    .out_chan(out_chan.source)
  );

  // predictor state
  longint pose_rot[9];
  longint pose_tr[3];
  bit     pose_started;

  tb_mdhf_types_pkg::pose_row_t expected_rows[$];
  int  mismatch_count;
  bit  sink_stall_on;
  bit  source_gap_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamp_rot(longint v);
    return clamp(v, -ONE, ONE);
  endfunction

  function automatic longint clamp_tr(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic void cordic_sin_cos(input logic [15:0] ang, output longint s,
                                         output longint c);
    logic [31:0] a;
    bit     flip;
    longint x, y, z, nx;
    a = {ang, 16'h0000};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a[31] = ~a[31];
    z = longint'($signed(a));
    x = mdhf_pkg::CORDIC_GAIN_Q30;
    y = 0;
    for (int i = 0; i < mdhf_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= longint'(mdhf_pkg::atan_turn(i[4:0]));
      end else begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += longint'(mdhf_pkg::atan_turn(i[4:0]));
      end
      x = nx;
    end
    x = round_shift(x, 30 - FRAC);
    y = round_shift(y, 30 - FRAC);
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_rot(x);
    s = clamp_rot(y);
  endfunction

  function automatic longint rot_product(longint p, longint q);
    return clamp_rot(round_shift(p * q, FRAC));
  endfunction

  function automatic void pose_clear();
    for (int i = 0; i < 9; i++) pose_rot[i] = (i % 4 == 0) ? ONE : 0;
    for (int i = 0; i < 3; i++) pose_tr[i] = 0;
    pose_started = 1'b0;
  endfunction

  // folds one joint into the pose and queues the three rows on a last joint
  function automatic void chain_joint(tb_mdhf_types_pkg::joint_req_t j);
    longint sa, ca, st, ct, d, sum, tsum;
    longint lr[9], lt[3], nr[9], nt[3];
    tb_mdhf_types_pkg::pose_row_t row;
    d = longint'(j.link_offset);
    cordic_sin_cos(j.link_twist, sa, ca);
    cordic_sin_cos(j.joint_angle, st, ct);
    lr[0] = ct; lr[1] = -st; lr[2] = 0;
    lr[3] = rot_product(st, ca); lr[4] = rot_product(ct, ca); lr[5] = -sa;
    lr[6] = rot_product(st, sa); lr[7] = rot_product(ct, sa); lr[8] = ca;
    lt[0] = longint'(j.link_length);
    lt[1] = clamp_tr(round_shift((-sa) * d, FRAC));
    lt[2] = clamp_tr(round_shift(ca * d, FRAC));
    if (!pose_started) begin
      nr = lr;
      nt = lt;
    end else begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          sum = 0;
          for (int k = 0; k < 3; k++) sum += pose_rot[r*3+k] * lr[k*3+c];
          nr[r*3+c] = clamp_rot(round_shift(sum, FRAC));
        end
        tsum = 0;
        for (int k = 0; k < 3; k++) tsum += pose_rot[r*3+k] * lt[k];
        nt[r] = clamp_tr(round_shift(tsum, FRAC) + pose_tr[r]);
      end
    end
    pose_rot = nr;
    pose_tr = nt;
    pose_started = 1'b1;
    if (j.last_joint) begin
      for (int r = 0; r < 3; r++) begin
        row.row_index   = r[1:0];
        row.rot_col0    = pose_rot[r*3][17:0];
        row.rot_col1    = pose_rot[r*3+1][17:0];
        row.rot_col2    = pose_rot[r*3+2][17:0];
        row.translation = pose_tr[r][31:0];
        row.last_row    = (r == 2);
        expected_rows.push_back(row);
      end
      pose_clear();
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // valid stays high after an accepted request until the next idle or drain
  task automatic send_joint(tb_mdhf_types_pkg::joint_req_t j);
    bit gap;
    gap = source_gap_on && ($urandom_range(99) < 37);
    if (gap) begin
      in_chan.valid <= 1'b0;
      while (gap) begin
        @(posedge clk);
        gap = source_gap_on && ($urandom_range(99) < 37);
      end
    end
    in_chan.valid       <= 1'b1;
    in_chan.link_length <= j.link_length;
    in_chan.link_twist  <= j.link_twist;
    in_chan.link_offset <= j.link_offset;
    in_chan.joint_angle <= j.joint_angle;
    in_chan.last_joint  <= j.last_joint;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    chain_joint(j);
  endtask

  function automatic tb_mdhf_types_pkg::joint_req_t make_joint(longint a, int tw, longint d,
                                                               int th, bit last);
    tb_mdhf_types_pkg::joint_req_t j;
    j.link_length = a[31:0];
    j.link_twist  = tw[15:0];
    j.link_offset = d[31:0];
    j.joint_angle = th[15:0];
    j.last_joint  = last;
    return j;
  endfunction

  function automatic tb_mdhf_types_pkg::joint_req_t random_joint(bit last);
    tb_mdhf_types_pkg::joint_req_t j;
    int sel;
    sel = $urandom_range(9);
    j.link_length = (sel == 0) ? $urandom : $signed($urandom_range(32'h60000)) - 32'sh30000;
    j.link_offset = (sel == 1) ? $urandom : $signed($urandom_range(32'h60000)) - 32'sh30000;
    j.link_twist  = (sel == 2) ? 16'(16'h4000 * $urandom_range(3)) : 16'($urandom);
    j.joint_angle = 16'($urandom);
    j.last_joint  = last;
    return j;
  endfunction

  task automatic wait_rows_drained();
    in_chan.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // output side: random backpressure and in-order row compare
  initial begin
    tb_mdhf_types_pkg::pose_row_t want;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_chan.ready <= !(sink_stall_on && ($urandom_range(99) < 37));
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected row", out_chan.row_index, -1);
        end else begin
          want = expected_rows.pop_front();
          if (out_chan.row_index !== want.row_index)
            report_mismatch("row_index", out_chan.row_index, want.row_index);
          if (out_chan.rot_col0 !== want.rot_col0)
            report_mismatch("rot_col0", out_chan.rot_col0, want.rot_col0);
          if (out_chan.rot_col1 !== want.rot_col1)
            report_mismatch("rot_col1", out_chan.rot_col1, want.rot_col1);
          if (out_chan.rot_col2 !== want.rot_col2)
            report_mismatch("rot_col2", out_chan.rot_col2, want.rot_col2);
          if (out_chan.translation !== want.translation)
            report_mismatch("translation", out_chan.translation, want.translation);
          if (out_chan.last_row !== want.last_row)
            report_mismatch("last_row", out_chan.last_row, want.last_row);
        end
      end
    end
  end

  task automatic test_single_joint_chains();
    int ang[8] = '{0, 16384, 32768, 49152, 65535, 8192, 16383, 32769};
    for (int i = 0; i < 8; i++)
      send_joint(make_joint(i * 65536, ang[7-i], -i * 32768, ang[i], 1'b1));
    send_joint(make_joint(64'sh7fffffff, 16'hffff, 64'sh7fffffff, 16'h0000, 1'b1));
    send_joint(make_joint(-64'sh80000000, 16'h0000, -64'sh80000000, 16'hffff, 1'b1));
    send_joint(make_joint(-64'sh80000000, 16'h4000, 64'sh7fffffff, 16'hc000, 1'b1));
  endtask

  task automatic test_saturating_chain();
    // translation sums run into the 32-bit limits
    send_joint(make_joint(64'sh7fffffff, 0, 64'sh7fffffff, 0, 1'b0));
    send_joint(make_joint(64'sh7fffffff, 0, 64'sh7fffffff, 0, 1'b1));
    send_joint(make_joint(-64'sh80000000, 16'h8000, -64'sh80000000, 16'h8000, 1'b0));
    send_joint(make_joint(-64'sh80000000, 16'h8000, -64'sh80000000, 16'h8000, 1'b0));
    send_joint(make_joint(-64'sh80000000, 16'h4000, 64'sh7fffffff, 16'h2000, 1'b1));
  endtask

  task automatic test_long_chain_unbroken();
    sink_stall_on = 1'b0;
    source_gap_on = 1'b0;
    for (int i = 0; i < 7; i++) send_joint(random_joint(i == 6));
    sink_stall_on = 1'b1;
    source_gap_on = 1'b1;
  endtask

  task automatic test_random_chains(int joints);
    int len;
    int sent;
    sent = 0;
    while (sent < joints) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
      for (int k = 0; k < len; k++) send_joint(random_joint(k == len - 1));
      sent += len;
      // now and then, hold off until the pose rows have all come back
      if ($urandom_range(7) == 0) wait_rows_drained();
    end
  endtask

  initial begin
    mismatch_count = 0;
    sink_stall_on = 1'b1;
    source_gap_on = 1'b1;
    pose_clear();
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.link_length <= '0;
    in_chan.link_twist <= '0;
    in_chan.link_offset <= '0;
    in_chan.joint_angle <= '0;
    in_chan.last_joint <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_joint_chains();
    test_saturating_chain();
    wait_rows_drained();
    test_long_chain_unbroken();
    test_random_chains(110);
    wait_rows_drained();
    repeat (400) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/mdhf_pkg.sv
rtl/mdhf_if.sv
rtl/mdhf_queue.sv
rtl/mdhf_front.sv
rtl/mdhf_back.sv
rtl/mdh_forward_kinematics_chain_unit.sv
tb/sv/tb_mdhf_if.sv
tb/sv/tb_mdh_forward_kinematics_chain_unit.sv
